@@ hw/rtl/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptt_pkg
// shared widths, codes and types of the priority timer table
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int TIME_W          = 48;
  localparam int ID_W            = 32;
  localparam int PERIOD_W        = 32;
  localparam int PRIO_W          = 2;
  localparam int PRIO_LEVELS     = 1 << PRIO_W;
  localparam int ACTION_W        = 2;
  localparam int KIND_W          = 2;
  localparam int STATUS_W        = 2;
  localparam int MAX_RESULTS     = 16;
  localparam int RES_CNT_W       = $clog2(MAX_RESULTS);
  localparam int DEF_TABLE_DEPTH = 16;

  // input actions
  localparam logic [ACTION_W-1:0] ACT_SCHEDULE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CANCEL   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SCHED   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOTHING = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_RUNNING = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL        = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND   = 2'd3;

  typedef enum logic {
    ALU_ADD_SAT,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t             op;
    logic [TIME_W-1:0]   a;
    logic [TIME_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0]   sum;
    logic                carry;
  } alu_res_t;

  typedef struct packed {
    logic [TIME_W-1:0]   expiry;
    logic [PERIOD_W-1:0] period;
    logic                rpt;
    logic [PRIO_W-1:0]   prio;
    logic [ID_W-1:0]     id;
  } entry_t;

endpackage

@@ hw/rtl/ptt_if.sv @@
// ----------------------------------------------------------------------------
// ptt_if
// command and result channels of the priority timer table
// ----------------------------------------------------------------------------
interface ptt_cmd_if import ptt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [TIME_W-1:0]     when;
  logic                  relative;
  logic [PERIOD_W-1:0]   interval;
  logic                  repeating;
  logic [PRIO_W-1:0]     priority_req;
  logic [ID_W-1:0]       cancel_id;

  modport source (
    output valid, action, when, relative, interval, repeating, priority_req, cancel_id,
    input  ready
  );
  modport sink (
    input  valid, action, when, relative, interval, repeating, priority_req, cancel_id,
    output ready
  );
endinterface

interface ptt_res_if import ptt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [STATUS_W-1:0]   status;
  logic [ID_W-1:0]       tmr_id;
  logic [PRIO_W-1:0]     fired_priority;
  logic                  last;

  modport source (
    output valid, kind, status, tmr_id, fired_priority, last,
    input  ready
  );
  modport sink (
    input  valid, kind, status, tmr_id, fired_priority, last,
    output ready
  );
endinterface

@@ hw/rtl/priority_timer_table.sv @@
// schedule: decode, adder step, reply; cancel: scan until the id matches or the
// last slot; tick: time step, full scan, then one pick and fire per expired entry
// up to MAX_RESULTS; throughput: one command at a time; a tick is held by the walk
// over the single read port and by stalls on the result channel
// reset: synchronous, active high; time, id counter, valid bits and enable
// clear at once, entry contents need no clearing
// ----------------------------------------------------------------------------
// priority_timer_table
// table of pending timers with prioritised expiry and periodic re-arm
// ----------------------------------------------------------------------------
module priority_timer_table import ptt_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_wr_en,
  input  logic   cfg_wr_data,
  ptt_cmd_if.sink   cmd,
  ptt_res_if.source res
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW:0]          DEPTH_CNT = (AW+1)'(TABLE_DEPTH);
  localparam logic [AW-1:0]        LAST_SLOT = AW'(TABLE_DEPTH - 1);
  localparam logic [RES_CNT_W-1:0] LAST_RES  = RES_CNT_W'(MAX_RESULTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCHED,
    S_TICK_INC,
    S_SCAN,
    S_PICK,
    S_FIRE,
    S_REPLY
  } state_t;

  state_t state;

  // latched command word
  logic [ACTION_W-1:0] act_q;
  logic [TIME_W-1:0]   when_q;
  logic                rel_q;
  logic [PERIOD_W-1:0] interval_q;
  logic                rpt_q;
  logic [PRIO_W-1:0]   prio_q;
  logic [ID_W-1:0]     cid_q;

  // block state
  logic                enable;
  logic [TIME_W-1:0]   current_time;
  logic [ID_W-1:0]     id_counter;
  logic [ID_W-1:0]     id_next;
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [PRIO_W-1:0]   entry_prio [TABLE_DEPTH];   // copy of priority for the selector

  // tick bookkeeping
  logic [TABLE_DEPTH-1:0] expired;                 // snapshot taken after the time step
  logic [AW:0]         iss_cnt;                    // scan read address counter
  logic                rd_vld;                     // read word present this cycle
  logic [AW-1:0]       rd_slot;
  logic [AW-1:0]       fire_slot;
  logic [RES_CNT_W-1:0] fired_n;

  // pending single-word reply
  logic [KIND_W-1:0]   rep_kind;
  logic [STATUS_W-1:0] rep_status;
  logic [ID_W-1:0]     rep_id;

  // output register
  logic                out_valid;
  logic [KIND_W-1:0]   out_kind;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_id;
  logic [PRIO_W-1:0]   out_prio;
  logic                out_last;
  logic                out_free;
  logic                out_load;

  // store and shared unit
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  entry_t              ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  entry_t              ram_rdata;
  alu_req_t            alu_req;
  alu_res_t            alu_res;

  // slot selection
  logic [AW-1:0]          free_slot;
  logic                   table_full;
  logic [TABLE_DEPTH-1:0] prio_mask [PRIO_LEVELS];
  logic [TABLE_DEPTH-1:0] cand;
  logic [AW-1:0]          pick_slot;
  logic                   fire_last;
  logic                   cancel_hit;

  assign cmd.ready = (state == S_IDLE);

  assign res.valid          = out_valid;
  assign res.kind           = out_kind;
  assign res.status         = out_status;
  assign res.tmr_id         = out_id;
  assign res.fired_priority = out_prio;
  assign res.last           = out_last;

  assign out_free   = !out_valid || res.ready;
  // a word is loaded into the output register this cycle
  assign out_load   = out_free && (state inside {S_FIRE, S_REPLY});
  assign id_next    = id_counter + ID_W'(1);
  assign table_full = &entry_valid;

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_slot = AW'(i);
      end
    end
  end

  // expired entries split by priority, highest non-empty class wins,
  // then the lowest slot within it
  always_comb begin
    for (int p = 0; p < PRIO_LEVELS; p++) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        prio_mask[p][i] = expired[i] && (entry_prio[i] == PRIO_W'(p));
      end
    end
    cand = '0;
    for (int p = 0; p < PRIO_LEVELS; p++) begin
      if (|prio_mask[p]) begin
        cand = prio_mask[p];
      end
    end
    pick_slot = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick_slot = AW'(i);
      end
    end
  end

  // final word of a tick: nothing left expired, or the result budget is used up
  assign fire_last  = !(|expired) || (fired_n == LAST_RES);
  assign cancel_hit = entry_valid[rd_slot] && (ram_rdata.id == cid_q);

  // shared adder operands per step
  always_comb begin
    alu_req.op = ALU_ADD_SAT;
    alu_req.a  = ram_rdata.expiry;
    alu_req.b  = {{(TIME_W-PERIOD_W){1'b0}}, ram_rdata.period};
    case (state)
      S_SCHED: begin
        alu_req.a = rel_q ? current_time : '0;
        alu_req.b = when_q;
      end
      S_TICK_INC: begin
        alu_req.a = current_time;
        alu_req.b = TIME_W'(1);
      end
      S_SCAN: begin
        // carry set when now >= expiry
        alu_req.op = ALU_SUB;
        alu_req.a  = current_time;
        alu_req.b  = ram_rdata.expiry;
      end
      default: begin
      end
    endcase
  end

  ptt_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // store port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = free_slot;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = iss_cnt[AW-1:0];
    case (state)
      S_SCHED: begin
        ram_we    = 1'b1;
        ram_wdata = '{expiry: alu_res.sum, period: interval_q, rpt: rpt_q,
                      prio: prio_q, id: id_next};
      end
      S_SCAN: begin
        ram_re = (iss_cnt < DEPTH_CNT);
      end
      S_PICK: begin
        ram_re    = |expired;
        ram_raddr = pick_slot;
      end
      S_FIRE: begin
        // re-arm writes back the fetched entry with the new expiry
        ram_we           = out_free && ram_rdata.rpt;
        ram_waddr        = fire_slot;
        ram_wdata.expiry = alu_res.sum;
      end
      default: begin
      end
    endcase
  end

  ptt_ram #(
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      enable       <= 1'b0;
      current_time <= '0;
      id_counter   <= '0;
      entry_valid  <= '0;
      expired      <= '0;
      iss_cnt      <= '0;
      rd_vld       <= 1'b0;
      fired_n      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        enable <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      // a read issued during the scan returns next cycle
      rd_vld <= (state == S_SCAN) && (iss_cnt < DEPTH_CNT);

      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            act_q      <= cmd.action;
            when_q     <= cmd.when;
            rel_q      <= cmd.relative;
            interval_q <= cmd.interval;
            rpt_q      <= cmd.repeating;
            prio_q     <= cmd.priority_req;
            cid_q      <= cmd.cancel_id;
            state      <= S_DECODE;
          end
        end

        S_DECODE: begin
          iss_cnt <= '0;
          case (act_q)
            ACT_SCHEDULE: begin
              rep_kind <= KIND_SCHED;
              rep_id   <= '0;
              if (!enable) begin
                rep_status <= STATUS_NOT_RUNNING;
                state      <= S_REPLY;
              end else if (table_full) begin
                rep_status <= STATUS_FULL;
                state      <= S_REPLY;
              end else begin
                state <= S_SCHED;
              end
            end
            ACT_CANCEL: begin
              state <= S_SCAN;
            end
            ACT_TICK: begin
              state <= S_TICK_INC;
            end
            default: begin
              // unknown action: no effect, no word
              state <= S_IDLE;
            end
          endcase
        end

        S_SCHED: begin
          entry_valid[free_slot] <= 1'b1;
          entry_prio[free_slot]  <= prio_q;
          id_counter             <= id_next;
          rep_kind               <= KIND_SCHED;
          rep_status             <= STATUS_OK;
          rep_id                 <= id_next;
          state                  <= S_REPLY;
        end

        S_TICK_INC: begin
          current_time <= alu_res.sum;
          expired      <= '0;
          state        <= S_SCAN;
        end

        S_SCAN: begin
          // reads issue one slot a cycle, the compare works on the registered read word
          if (iss_cnt < DEPTH_CNT) begin
            iss_cnt <= iss_cnt + (AW+1)'(1);
            rd_slot <= iss_cnt[AW-1:0];
          end
          if (rd_vld) begin
            if (act_q == ACT_CANCEL) begin
              rep_kind <= KIND_CANCEL;
              rep_id   <= cid_q;
              if (cancel_hit) begin
                entry_valid[rd_slot] <= 1'b0;
                rep_status           <= STATUS_OK;
                state                <= S_REPLY;
              end else if (rd_slot == LAST_SLOT) begin
                rep_status <= STATUS_NOT_FOUND;
                state      <= S_REPLY;
              end
            end else begin
              if (entry_valid[rd_slot] && alu_res.carry) begin
                expired[rd_slot] <= 1'b1;
              end
              if (rd_slot == LAST_SLOT) begin
                fired_n <= '0;
                state   <= S_PICK;
              end
            end
          end
        end

        S_PICK: begin
          if (|expired) begin
            fire_slot          <= pick_slot;
            expired[pick_slot] <= 1'b0;
            state              <= S_FIRE;
          end else begin
            rep_kind   <= KIND_NOTHING;
            rep_status <= STATUS_OK;
            rep_id     <= '0;
            state      <= S_REPLY;
          end
        end

        S_FIRE: begin
          if (out_free) begin
            out_kind   <= KIND_FIRED;
            out_status <= STATUS_OK;
            out_id     <= ram_rdata.id;
            out_prio   <= ram_rdata.prio;
            out_last   <= fire_last;
            fired_n    <= fired_n + RES_CNT_W'(1);
            if (!ram_rdata.rpt) begin
              entry_valid[fire_slot] <= 1'b0;
            end
            state <= fire_last ? S_IDLE : S_PICK;
          end
        end

        S_REPLY: begin
          if (out_free) begin
            out_kind   <= rep_kind;
            out_status <= rep_status;
            out_id     <= rep_id;
            out_prio   <= '0;
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/ptt_alu.sv @@
// ----------------------------------------------------------------------------
// ptt_alu
// shared 48-bit adder: saturating add or subtract with carry as a >= b
// ----------------------------------------------------------------------------
module ptt_alu import ptt_pkg::*; (
  input  alu_req_t req,
  output alu_res_t res
);

  logic [TIME_W-1:0] b_eff;
  logic [TIME_W:0]   total;
  logic              is_sub;

  assign is_sub = (req.op == ALU_SUB);
  assign b_eff  = is_sub ? ~req.b : req.b;
  assign total  = {1'b0, req.a} + {1'b0, b_eff} + {{TIME_W{1'b0}}, is_sub};

  assign res.carry = total[TIME_W];
  // saturate on overflow of an add
  assign res.sum   = (!is_sub && total[TIME_W]) ? {TIME_W{1'b1}} : total[TIME_W-1:0];

endmodule

@@ hw/rtl/ptt_ram.sv @@
// ----------------------------------------------------------------------------
// ptt_ram
// timer entry store, one write and one registered read port
// ----------------------------------------------------------------------------
module ptt_ram import ptt_pkg::*; #(
  parameter int DEPTH = DEF_TABLE_DEPTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/ptt_checker.sv @@
// ----------------------------------------------------------------------------
// ptt_checker
// port-level checks of the priority timer table, bound to the top level
// ----------------------------------------------------------------------------
module ptt_checker import ptt_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input logic                res_valid,
  input logic                res_ready,
  input logic [KIND_W-1:0]   kind,
  input logic [STATUS_W-1:0] status,
  input logic [ID_W-1:0]     tmr_id,
  input logic [PRIO_W-1:0]   fired_priority,
  input logic                last
);

  // a stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(status) &&
      $stable(tmr_id) && $stable(fired_priority) && $stable(last))
    else $error("result word changed while stalled");

  // one command at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while busy");

  // replies are single words with no priority
  a_reply_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind != KIND_FIRED |-> last && fired_priority == '0)
    else $error("reply word malformed");

  // a fired timer is always ok
  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_FIRED |-> status == STATUS_OK)
    else $error("fired word with bad status");

  // refused schedule carries no id
  a_refused_no_id: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_SCHED && status != STATUS_OK |-> tmr_id == '0)
    else $error("refused schedule with an id");

endmodule

bind priority_timer_table ptt_checker u_ptt_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .kind           (res.kind),
  .status         (res.status),
  .tmr_id         (res.tmr_id),
  .fired_priority (res.fired_priority),
  .last           (res.last)
);
